@@ rtl/shore_distance_tile_classifier_macros.svh @@
// assertion helpers used by the top-level rtl file
`ifndef SHORE_DISTANCE_TILE_CLASSIFIER_MACROS_SVH
`define SHORE_DISTANCE_TILE_CLASSIFIER_MACROS_SVH

// same-cycle implication
`define SDTC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SDTC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/sdtc_pkg.sv @@
package sdtc_pkg;

   localparam int DIM_W      = 7;
   localparam int COL_W      = 6;
   localparam int ROW_W      = 6;
   localparam int SAMPLE_W   = 16;
   localparam int TILE_W     = 4;
   localparam int CLS_W      = 2;
   localparam int DIST_W     = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [1:0] MODE_LOAD = 2'd0;
   localparam logic [1:0] MODE_RUN  = 2'd1;
   localparam logic [1:0] MODE_READ = 2'd2;

   localparam logic [CLS_W-1:0] CLS_WATER = 2'd0;
   localparam logic [CLS_W-1:0] CLS_SAND  = 2'd1;
   localparam logic [CLS_W-1:0] CLS_GRASS = 2'd2;

   localparam logic [DIST_W-1:0] DIST_SAT = 3'd7;

   localparam logic [TILE_W-1:0] TILE_SAND       = 4'd0;
   localparam logic [TILE_W-1:0] TILE_GRASS_NEAR = 4'd1;
   localparam logic [TILE_W-1:0] TILE_GRASS_MID  = 4'd2;
   localparam logic [TILE_W-1:0] TILE_GRASS_FAR  = 4'd3;
   localparam logic [TILE_W-1:0] TILE_WATER_BASE = 4'd3;
   localparam logic [TILE_W-1:0] TILE_WATER_NEAR = 4'd4;
   localparam logic [TILE_W-1:0] TILE_WATER_FAR  = 4'd8;

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_WIDTH   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_HEIGHT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WATER_LEVEL  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GRASS_LEVEL  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TEST_PATTERN = 3'd4;

   typedef struct packed {
      logic cls_rd;
      logic cls_wr;
      logic dist_rd;
      logic dist_wr;
   } sdtc_mem_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } sdtc_scan_stat_type;

endpackage

@@ rtl/sdtc_if.sv @@
interface sdtc_req_if;
   import sdtc_pkg::*;
   logic                valid;
   logic                ready;
   logic [1:0]          mode;
   logic [COL_W-1:0]    col;
   logic [ROW_W-1:0]    row;
   logic [SAMPLE_W-1:0] sample;

   modport source (output valid, mode, col, row, sample, input ready);
   modport sink (input valid, mode, col, row, sample, output ready);
endinterface

interface sdtc_rsp_if;
   import sdtc_pkg::*;
   logic              valid;
   logic              ready;
   logic [TILE_W-1:0] tile;
   logic              is_reply;

   modport source (output valid, tile, is_reply, input ready);
   modport sink (input valid, tile, is_reply, output ready);
endinterface

interface sdtc_csr_if;
   import sdtc_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/sdtc_store.sv @@
module sdtc_store #(
   parameter int Depth = 4096,
   parameter int AddrW = 12
) (
   input  logic                           clock,
   input  sdtc_pkg::sdtc_mem_ctl_type     ctl,
   input  logic [AddrW-1:0]               cls_rd_addr,
   input  logic [AddrW-1:0]               cls_wr_addr,
   input  logic [sdtc_pkg::CLS_W-1:0]     cls_wr_data,
   input  logic [AddrW-1:0]               dist_addr_a,
   input  logic [AddrW-1:0]               dist_addr_b,
   input  logic [AddrW-1:0]               dist_wr_addr,
   input  logic [sdtc_pkg::DIST_W-1:0]    dist_wr_data,
   output logic [sdtc_pkg::CLS_W-1:0]     cls_q,
   output logic [sdtc_pkg::DIST_W-1:0]    dist_qa,
   output logic [sdtc_pkg::DIST_W-1:0]    dist_qb
);
   import sdtc_pkg::*;

   logic [CLS_W-1:0]  cls_mem  [Depth];
   logic [DIST_W-1:0] dist_mem [Depth];

   logic [CLS_W-1:0]  cls_q_ff;
   logic [DIST_W-1:0] dist_qa_ff;
   logic [DIST_W-1:0] dist_qb_ff;

   // read data holds while no read is issued
   always_ff @(posedge clock) begin
      if (ctl.cls_wr) begin
         cls_mem[cls_wr_addr] <= cls_wr_data;
      end
      if (ctl.cls_rd) begin
         cls_q_ff <= cls_mem[cls_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.dist_wr) begin
         dist_mem[dist_wr_addr] <= dist_wr_data;
      end
      if (ctl.dist_rd) begin
         dist_qa_ff <= dist_mem[dist_addr_a];
         dist_qb_ff <= dist_mem[dist_addr_b];
      end
   end

   assign cls_q   = cls_q_ff;
   assign dist_qa = dist_qa_ff;
   assign dist_qb = dist_qb_ff;

endmodule

@@ rtl/sdtc_scan.sv @@
module sdtc_scan #(
   parameter int MaxCols = 64,
   parameter int AddrW   = 12
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [sdtc_pkg::DIM_W-1:0]      grid_w,
   input  logic [sdtc_pkg::DIM_W-1:0]      grid_h,
   input  logic [sdtc_pkg::CLS_W-1:0]      cls_q,
   input  logic [sdtc_pkg::DIST_W-1:0]     dist_qa,
   input  logic [sdtc_pkg::DIST_W-1:0]     dist_qb,
   output sdtc_pkg::sdtc_mem_ctl_type      ctl,
   output logic [AddrW-1:0]                cls_addr,
   output logic [AddrW-1:0]                dist_addr_a,
   output logic [AddrW-1:0]                dist_addr_b,
   output logic [AddrW-1:0]                wr_addr,
   output logic [sdtc_pkg::DIST_W-1:0]     wr_data,
   output sdtc_pkg::sdtc_scan_stat_type    stat
);
   import sdtc_pkg::*;

   localparam logic [AddrW-1:0] ROW_STEP = AddrW'(MaxCols);

   typedef enum logic [1:0] {S_IDLE, S_FWD, S_BWD, S_DRAIN} state_type;

   state_type         state_ff, state_in;
   logic [DIM_W-1:0]  row_ff, row_in;
   logic [DIM_W-1:0]  col_ff, col_in;
   logic [AddrW-1:0]  base_ff, base_in;
   logic              done_ff, done_in;
   logic              s1_valid_ff;
   logic              s1_bwd_ff;
   logic              s1_vert_ff;
   logic              s1_side_ff;
   logic              s1_fwd_a_ff;
   logic              s1_fwd_b_ff;
   logic [AddrW-1:0]  s1_addr_ff;
   logic [DIST_W-1:0] last_ff;

   logic [AddrW-1:0]  idx;
   logic [AddrW-1:0]  up_addr;
   logic [AddrW-1:0]  down_addr;
   logic [DIM_W-1:0]  col_max;
   logic [DIM_W-1:0]  row_max;
   logic              issue;
   logic              bwd;
   logic [DIST_W-1:0] val_a;
   logic [DIST_W-1:0] val_b;
   logic [DIST_W-1:0] cell_dist;

   function automatic logic [DIST_W-1:0] sat_inc(input logic [DIST_W-1:0] d);
      return (d == DIST_SAT) ? DIST_SAT : d + DIST_W'(1);
   endfunction

   function automatic logic [DIST_W-1:0] min_d(input logic [DIST_W-1:0] a,
                                               input logic [DIST_W-1:0] b);
      return (b < a) ? b : a;
   endfunction

   assign idx       = base_ff + AddrW'(col_ff);
   assign up_addr   = idx - ROW_STEP;
   assign down_addr = idx + ROW_STEP;
   assign col_max   = grid_w - DIM_W'(1);
   assign row_max   = grid_h - DIM_W'(1);
   assign issue     = (state_ff == S_FWD) || (state_ff == S_BWD);
   assign bwd       = (state_ff == S_BWD);

   assign cls_addr    = idx;
   assign dist_addr_a = bwd ? idx : up_addr;
   assign dist_addr_b = down_addr;

   assign ctl.cls_rd  = (state_ff == S_FWD);
   assign ctl.cls_wr  = 1'b0;
   assign ctl.dist_rd = issue;
   assign ctl.dist_wr = s1_valid_ff;

   // the cell written last cycle may be a neighbor read this cycle
   assign val_a = s1_fwd_a_ff ? last_ff : dist_qa;
   assign val_b = s1_fwd_b_ff ? last_ff : dist_qb;

   always_comb begin
      if (!s1_bwd_ff) begin
         cell_dist = (cls_q == CLS_SAND) ? '0 : DIST_SAT;
         if (s1_vert_ff) cell_dist = min_d(cell_dist, sat_inc(val_a));
      end else begin
         cell_dist = val_a;
         if (s1_vert_ff) cell_dist = min_d(cell_dist, sat_inc(val_b));
      end
      if (s1_side_ff) cell_dist = min_d(cell_dist, sat_inc(last_ff));
   end

   assign wr_addr = s1_addr_ff;
   assign wr_data = cell_dist;

   always_comb begin
      state_in = state_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      base_in  = base_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               row_in   = '0;
               col_in   = '0;
               base_in  = '0;
               state_in = S_FWD;
            end
         end
         S_FWD: begin
            // backward pass starts on the cell where the forward pass ends
            if (col_ff == col_max && row_ff == row_max) begin
               state_in = S_BWD;
            end else if (col_ff == col_max) begin
               col_in  = '0;
               row_in  = row_ff + DIM_W'(1);
               base_in = base_ff + ROW_STEP;
            end else begin
               col_in = col_ff + DIM_W'(1);
            end
         end
         S_BWD: begin
            if (col_ff == '0 && row_ff == '0) begin
               state_in = S_DRAIN;
            end else if (col_ff == '0) begin
               col_in  = col_max;
               row_in  = row_ff - DIM_W'(1);
               base_in = base_ff - ROW_STEP;
            end else begin
               col_in = col_ff - DIM_W'(1);
            end
         end
         S_DRAIN: begin
            state_in = S_IDLE;
            done_in  = 1'b1;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      s1_bwd_ff   <= bwd;
      s1_addr_ff  <= idx;
      s1_vert_ff  <= bwd ? (row_ff != row_max) : (row_ff != '0);
      s1_side_ff  <= bwd ? (col_ff != col_max) : (col_ff != '0);
      s1_fwd_a_ff <= s1_valid_ff && (dist_addr_a == s1_addr_ff);
      s1_fwd_b_ff <= bwd && s1_valid_ff && (down_addr == s1_addr_ff);
      if (s1_valid_ff) begin
         last_ff <= cell_dist;
      end
      if (reset) begin
         state_ff    <= S_IDLE;
         row_ff      <= '0;
         col_ff      <= '0;
         base_ff     <= '0;
         done_ff     <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
         base_ff     <= base_in;
         done_ff     <= done_in;
         s1_valid_ff <= issue;
      end
   end

   assign stat.busy = (state_ff != S_IDLE);
   assign stat.done = done_ff;

endmodule

@@ rtl/shore_distance_tile_classifier.sv @@
// channel    dir   handshake     payload
// req_port   in    valid/ready   mode, col, row, sample
// rsp_port   out   valid/ready   tile, is_reply
// csr_port   in    valid/ready   index, data
//
// load and read words are taken one per cycle while no run is in progress and the pending
// read can move on; a read reply comes from the registered read of the class and distance memories
// a run steps one cell per cycle through the distance memory,
// in a forward and a backward raster pass, then sends the acknowledge word
// reset is synchronous; the memories are not cleared and hold garbage until loaded
// while the response register is held, one read waits in a pending stage and input stalls

`include "shore_distance_tile_classifier_macros.svh"

module shore_distance_tile_classifier #(
   parameter int MAX_COLS = 64,
   parameter int MAX_ROWS = 64
) (
   input logic         clock,
   input logic         reset,
   sdtc_req_if.sink    req_port,
   sdtc_rsp_if.source  rsp_port,
   sdtc_csr_if.sink    csr_port
);
   import sdtc_pkg::*;

   localparam int CELLS  = MAX_COLS * MAX_ROWS;
   localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;

   typedef enum logic [1:0] {T_IDLE, T_RUN, T_ACK} state_type;

   logic [DIM_W-1:0]    grid_width_ff;
   logic [DIM_W-1:0]    grid_height_ff;
   logic [SAMPLE_W-1:0] water_level_ff;
   logic [SAMPLE_W-1:0] grass_level_ff;
   logic                test_pattern_ff;

   state_type           state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [TILE_W-1:0]   rsp_tile_ff, rsp_tile_in;
   logic                rsp_is_reply_ff, rsp_is_reply_in;
   logic                pend_valid_ff, pend_valid_in;
   logic                pend_inside_ff, pend_inside_in;
   logic                pend_tp_ff, pend_tp_in;
   logic [TILE_W-1:0]   pend_tp_tile_ff, pend_tp_tile_in;

   logic [DIM_W-1:0]    grid_w;
   logic [DIM_W-1:0]    grid_h;
   logic                in_grid;
   logic [ADDR_W-1:0]   req_idx;
   logic [CLS_W-1:0]    load_cls;
   logic                req_accept;
   logic                ld_wr;
   logic                rd_go;
   logic                run_go;
   logic                rsp_free;
   logic                pend_move;
   logic [TILE_W-1:0]   pend_tile;

   sdtc_mem_ctl_type    mem_ctl;
   sdtc_mem_ctl_type    scan_ctl;
   sdtc_scan_stat_type  scan_stat;
   logic [ADDR_W-1:0]   scan_cls_addr;
   logic [ADDR_W-1:0]   scan_addr_a;
   logic [ADDR_W-1:0]   scan_addr_b;
   logic [ADDR_W-1:0]   scan_wr_addr;
   logic [DIST_W-1:0]   scan_wr_data;
   logic [CLS_W-1:0]    cls_q;
   logic [DIST_W-1:0]   dist_qa;
   logic [DIST_W-1:0]   dist_qb;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input int maxv);
      if (v == '0) return DIM_W'(1);
      if (int'(v) > maxv) return DIM_W'(maxv);
      return v;
   endfunction

   function automatic logic [TILE_W-1:0] tile_of(input logic [CLS_W-1:0] cls,
                                                 input logic [DIST_W-1:0] d);
      priority if (cls == CLS_SAND) begin
         return TILE_SAND;
      end else if (cls == CLS_GRASS) begin
         if (d <= DIST_W'(1)) return TILE_GRASS_NEAR;
         if (d == DIST_W'(2)) return TILE_GRASS_MID;
         return TILE_GRASS_FAR;
      end else begin
         if (d <= DIST_W'(1)) return TILE_WATER_NEAR;
         if (d >= DIST_W'(5)) return TILE_WATER_FAR;
         return TILE_WATER_BASE + TILE_W'(d);
      end
   endfunction

   // configuration
   assign csr_port.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff   <= DIM_W'(64);
         grid_height_ff  <= DIM_W'(64);
         water_level_ff  <= SAMPLE_W'(19661);
         grass_level_ff  <= SAMPLE_W'(32768);
         test_pattern_ff <= 1'b0;
      end else if (csr_port.valid && csr_port.ready) begin
         unique case (csr_port.index)
            CSR_GRID_WIDTH:   grid_width_ff   <= csr_port.data[DIM_W-1:0];
            CSR_GRID_HEIGHT:  grid_height_ff  <= csr_port.data[DIM_W-1:0];
            CSR_WATER_LEVEL:  water_level_ff  <= csr_port.data[SAMPLE_W-1:0];
            CSR_GRASS_LEVEL:  grass_level_ff  <= csr_port.data[SAMPLE_W-1:0];
            CSR_TEST_PATTERN: test_pattern_ff <= csr_port.data[0];
            default: ;
         endcase
      end
   end

   // input decode
   assign grid_w  = clamp_dim(grid_width_ff, MAX_COLS);
   assign grid_h  = clamp_dim(grid_height_ff, MAX_ROWS);
   assign in_grid = (DIM_W'(req_port.col) < grid_w) && (DIM_W'(req_port.row) < grid_h);
   assign req_idx = ADDR_W'(int'(req_port.row) * MAX_COLS + int'(req_port.col));

   always_comb begin
      if (req_port.sample < water_level_ff) begin
         load_cls = CLS_WATER;
      end else if (req_port.sample < grass_level_ff) begin
         load_cls = CLS_SAND;
      end else begin
         load_cls = CLS_GRASS;
      end
   end

   assign rsp_free   = !rsp_valid_ff || rsp_port.ready;
   assign pend_move  = pend_valid_ff && rsp_free;
   assign req_port.ready = (state_ff == T_IDLE) && (!pend_valid_ff || rsp_free);
   assign req_accept = req_port.valid && req_port.ready;
   assign ld_wr      = req_accept && (req_port.mode == MODE_LOAD) && in_grid;
   assign rd_go      = req_accept && (req_port.mode == MODE_READ);
   assign run_go     = req_accept && (req_port.mode == MODE_RUN);

   // memory ports: the scan owns them while a run is in progress
   assign mem_ctl.cls_wr  = ld_wr;
   assign mem_ctl.cls_rd  = scan_ctl.cls_rd || rd_go;
   assign mem_ctl.dist_rd = scan_ctl.dist_rd || rd_go;
   assign mem_ctl.dist_wr = scan_ctl.dist_wr;

   sdtc_store #(
      .Depth (CELLS),
      .AddrW (ADDR_W)
   ) u_store (
      .clock        (clock),
      .ctl          (mem_ctl),
      .cls_rd_addr  (scan_stat.busy ? scan_cls_addr : req_idx),
      .cls_wr_addr  (req_idx),
      .cls_wr_data  (load_cls),
      .dist_addr_a  (scan_stat.busy ? scan_addr_a : req_idx),
      .dist_addr_b  (scan_addr_b),
      .dist_wr_addr (scan_wr_addr),
      .dist_wr_data (scan_wr_data),
      .cls_q        (cls_q),
      .dist_qa      (dist_qa),
      .dist_qb      (dist_qb)
   );

   sdtc_scan #(
      .MaxCols (MAX_COLS),
      .AddrW   (ADDR_W)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .start       (run_go),
      .grid_w      (grid_w),
      .grid_h      (grid_h),
      .cls_q       (cls_q),
      .dist_qa     (dist_qa),
      .dist_qb     (dist_qb),
      .ctl         (scan_ctl),
      .cls_addr    (scan_cls_addr),
      .dist_addr_a (scan_addr_a),
      .dist_addr_b (scan_addr_b),
      .wr_addr     (scan_wr_addr),
      .wr_data     (scan_wr_data),
      .stat        (scan_stat)
   );

   assign pend_tile = !pend_inside_ff ? TILE_SAND :
                      pend_tp_ff      ? pend_tp_tile_ff : tile_of(cls_q, dist_qa);

   always_comb begin
      state_in        = state_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_tile_in     = rsp_tile_ff;
      rsp_is_reply_in = rsp_is_reply_ff;
      pend_valid_in   = pend_valid_ff;
      pend_inside_in  = pend_inside_ff;
      pend_tp_in      = pend_tp_ff;
      pend_tp_tile_in = pend_tp_tile_ff;

      if (rsp_port.ready) rsp_valid_in = 1'b0;

      if (pend_move) begin
         rsp_valid_in    = 1'b1;
         rsp_tile_in     = pend_tile;
         rsp_is_reply_in = 1'b1;
         pend_valid_in   = 1'b0;
      end

      unique case (state_ff)
         T_IDLE: if (run_go) state_in = T_RUN;
         T_RUN:  if (scan_stat.done) state_in = T_ACK;
         T_ACK: begin
            if (rsp_free) begin
               rsp_valid_in    = 1'b1;
               rsp_tile_in     = TILE_SAND;
               rsp_is_reply_in = 1'b0;
               state_in        = T_IDLE;
            end
         end
         default: state_in = T_IDLE;
      endcase

      if (rd_go) begin
         pend_valid_in   = 1'b1;
         pend_inside_in  = in_grid;
         pend_tp_in      = test_pattern_ff;
         // split at half height, grass on top
         pend_tp_tile_in = (DIM_W'(req_port.row) < (grid_h >> 1)) ?
                           TILE_GRASS_FAR : TILE_WATER_FAR;
      end
   end

   always_ff @(posedge clock) begin
      rsp_tile_ff     <= rsp_tile_in;
      rsp_is_reply_ff <= rsp_is_reply_in;
      pend_inside_ff  <= pend_inside_in;
      pend_tp_ff      <= pend_tp_in;
      pend_tp_tile_ff <= pend_tp_tile_in;
      if (reset) begin
         state_ff      <= T_IDLE;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   assign rsp_port.valid    = rsp_valid_ff;
   assign rsp_port.tile     = rsp_tile_ff;
   assign rsp_port.is_reply = rsp_is_reply_ff;

   `SDTC_ASSERT_IMPL(a_no_input_in_run, clock, reset, scan_stat.busy, !req_port.ready,
                     "input word taken during a run")
   `SDTC_ASSERT_NEXT(a_pend_held, clock, reset, pend_valid_ff && !rsp_free, pend_valid_ff,
                     "pending read reply lost")
   `SDTC_ASSERT_NEXT(a_ack_sent, clock, reset, (state_ff == T_ACK) && rsp_free,
                     rsp_valid_ff && !rsp_is_reply_ff, "run acknowledge not sent")
   `SDTC_ASSERT_IMPL(a_port_owner, clock, reset, rd_go, !scan_stat.busy && !scan_ctl.dist_wr,
                     "read issued while scan owns the memories")

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
   import sdtc_pkg::*;

   localparam int MAX_COLS      = 64;
   localparam int MAX_ROWS      = 64;
   localparam int SETTLE_CYCLES = 16;
   localparam int LONG_HOLD     = 400;

   localparam logic [1:0] MODE_NONE = 2'd3;

   typedef struct packed {
      logic [1:0]          mode;
      logic [COL_W-1:0]    col;
      logic [ROW_W-1:0]    row;
      logic [SAMPLE_W-1:0] sample;
   } cell_cmd_type;

   typedef struct packed {
      logic [TILE_W-1:0] tile;
      logic              is_reply;
   } tile_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sdtc_req_if req_if();
   sdtc_rsp_if rsp_if();
   sdtc_csr_if csr_if();

   shore_distance_tile_classifier dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_if),
      .rsp_port (rsp_if),
      .csr_port (csr_if)
   );

   // commands waiting for the driver, tiles waiting for the block
   cell_cmd_type  cell_cmds[$];
   tile_word_type pending_tiles[$];

   // predictor state
   logic [CLS_W-1:0]  class_map [0:MAX_COLS*MAX_ROWS-1];
   logic [DIST_W-1:0] dist_map  [0:MAX_COLS*MAX_ROWS-1];
   int   model_width, model_height, model_water, model_grass;
   logic model_pattern;

   // settings seen by the stimulus generator
   int plan_w, plan_h, plan_wl, plan_gl;

   int   failures = 0;
   logic req_took = 1'b0;
   logic rsp_took = 1'b0;
   int   send_wait = 0, send_burst = 0;
   int   recv_wait = 0, recv_burst = 0;
   int   hold_req = 0, hold_seen = 0;

   always #6 clock = ~clock;

   function automatic int clamp_dim(int v, int maxv);
      if (v < 1) return 1;
      if (v > maxv) return maxv;
      return v;
   endfunction

   function automatic logic [DIST_W-1:0] one_further(logic [DIST_W-1:0] d);
      return (d >= DIST_SAT) ? DIST_SAT : d + 3'd1;
   endfunction

   // idle cycles before the next word, with occasional runs of back-to-back words
   function automatic int pick_gap(inout int burst);
      if (burst > 0) begin
         burst--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         burst = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 18);
   endfunction

   function automatic bit predict_tile(input cell_cmd_type cmd, output tile_word_type word);
      int w, h, total, pos, r, c, k, idx;
      bit in_grid;
      logic [DIST_W-1:0] d, n;
      w = clamp_dim(model_width, MAX_COLS);
      h = clamp_dim(model_height, MAX_ROWS);
      in_grid = (cmd.col < w) && (cmd.row < h);
      idx = cmd.row * MAX_COLS + cmd.col;
      word = '0;
      case (cmd.mode)
         MODE_LOAD: begin
            if (in_grid) begin
               if (cmd.sample < model_water) class_map[idx] = CLS_WATER;
               else if (cmd.sample < model_grass) class_map[idx] = CLS_SAND;
               else class_map[idx] = CLS_GRASS;
            end
            return 0;
         end
         MODE_RUN: begin
            total = w * h;
            // forward raster pass takes the top and left neighbors
            for (pos = 0; pos < total; pos++) begin
               r = pos / w;
               c = pos % w;
               k = r * MAX_COLS + c;
               d = (class_map[k] == CLS_SAND) ? 3'd0 : DIST_SAT;
               if (r > 0) begin
                  n = one_further(dist_map[k - MAX_COLS]);
                  if (n < d) d = n;
               end
               if (c > 0) begin
                  n = one_further(dist_map[k - 1]);
                  if (n < d) d = n;
               end
               dist_map[k] = d;
            end
            // backward pass takes the bottom and right neighbors
            for (pos = total - 1; pos >= 0; pos--) begin
               r = pos / w;
               c = pos % w;
               k = r * MAX_COLS + c;
               d = dist_map[k];
               if (r + 1 < h) begin
                  n = one_further(dist_map[k + MAX_COLS]);
                  if (n < d) d = n;
               end
               if (c + 1 < w) begin
                  n = one_further(dist_map[k + 1]);
                  if (n < d) d = n;
               end
               dist_map[k] = d;
            end
            word.tile = TILE_SAND;
            word.is_reply = 1'b0;
            return 1;
         end
         MODE_READ: begin
            word.tile = TILE_SAND;
            word.is_reply = 1'b1;
            if (in_grid && model_pattern) begin
               word.tile = (cmd.row < h / 2) ? TILE_GRASS_FAR : TILE_WATER_FAR;
            end else if (in_grid) begin
               d = dist_map[idx];
               case (class_map[idx])
                  CLS_SAND: word.tile = TILE_SAND;
                  CLS_GRASS: word.tile = (d <= 1) ? TILE_GRASS_NEAR :
                                         (d == 2) ? TILE_GRASS_MID : TILE_GRASS_FAR;
                  default: word.tile = (d <= 1) ? TILE_WATER_NEAR :
                                       (d >= 5) ? TILE_WATER_FAR : TILE_WATER_NEAR + d - 4'd1;
               endcase
            end
            return 1;
         end
         default: return 0;
      endcase
   endfunction

   // accepted words: predict, check, track register writes
   always @(posedge clock) begin : watch_ports
      cell_cmd_type  cmd;
      tile_word_type want;
      req_took <= !reset && req_if.valid && req_if.ready;
      rsp_took <= !reset && rsp_if.valid && rsp_if.ready;
      if (reset) begin
         model_width = 64;
         model_height = 64;
         model_water = 19661;
         model_grass = 32768;
         model_pattern = 1'b0;
      end else begin
         if (csr_if.valid && csr_if.ready) begin
            case (csr_if.index)
               CSR_GRID_WIDTH:   model_width = csr_if.data[DIM_W-1:0];
               CSR_GRID_HEIGHT:  model_height = csr_if.data[DIM_W-1:0];
               CSR_WATER_LEVEL:  model_water = csr_if.data;
               CSR_GRASS_LEVEL:  model_grass = csr_if.data;
               CSR_TEST_PATTERN: model_pattern = csr_if.data[0];
               default: ;
            endcase
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (pending_tiles.size() == 0) begin
               $error("unexpected word: tile %0d is_reply %0d", rsp_if.tile, rsp_if.is_reply);
               failures++;
            end else begin
               want = pending_tiles.pop_front();
               if (rsp_if.tile !== want.tile) begin
                  $error("tile: expected %0d, actual %0d", want.tile, rsp_if.tile);
                  failures++;
               end
               if (rsp_if.is_reply !== want.is_reply) begin
                  $error("is_reply: expected %0d, actual %0d", want.is_reply, rsp_if.is_reply);
                  failures++;
               end
            end
         end
         if (req_if.valid && req_if.ready) begin
            cmd.mode = req_if.mode;
            cmd.col = req_if.col;
            cmd.row = req_if.row;
            cmd.sample = req_if.sample;
            if (predict_tile(cmd, want)) pending_tiles = {pending_tiles, want};
         end
      end
   end

   always @(negedge clock) begin : drive_cells
      cell_cmd_type cmd;
      if (reset) begin
         req_if.valid <= 1'b0;
         send_wait = 0;
      end else if (!req_if.valid || req_took) begin
         if (send_wait > 0) begin
            send_wait--;
            req_if.valid <= 1'b0;
         end else if (cell_cmds.size() != 0) begin
            cmd = cell_cmds.pop_front();
            req_if.mode <= cmd.mode;
            req_if.col <= cmd.col;
            req_if.row <= cmd.row;
            req_if.sample <= cmd.sample;
            req_if.valid <= 1'b1;
            send_wait = pick_gap(send_burst);
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin : drive_ready
      if (reset) begin
         rsp_if.ready <= 1'b0;
         recv_wait = 0;
      end else begin
         if (rsp_took) recv_wait = pick_gap(recv_burst);
         // long back-pressure so the block fills up and stalls its input
         if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            recv_wait = LONG_HOLD;
         end
         if (recv_wait > 0) begin
            recv_wait--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   function automatic void queue_cmd(logic [1:0] mode, int col, int row, int sample);
      cell_cmd_type cmd;
      cmd.mode = mode;
      cmd.col = col[COL_W-1:0];
      cmd.row = row[ROW_W-1:0];
      cmd.sample = sample[SAMPLE_W-1:0];
      cell_cmds = {cell_cmds, cmd};
   endfunction

   function automatic int pick_sample(int sand_pct);
      int roll;
      if ($urandom_range(0, 7) == 0) begin
         case ($urandom_range(0, 5))
            0: return 0;
            1: return 65535;
            2: return plan_wl;
            3: return (plan_wl - 1) & 16'hFFFF;
            4: return plan_gl;
            default: return (plan_gl - 1) & 16'hFFFF;
         endcase
      end
      roll = $urandom_range(0, 99);
      if (roll < sand_pct && plan_gl > plan_wl) return $urandom_range(plan_wl, plan_gl - 1);
      if (roll < sand_pct + (100 - sand_pct) * 6 / 10 && plan_wl > 0)
         return $urandom_range(0, plan_wl - 1);
      return $urandom_range(plan_gl, 65535);
   endfunction

   task automatic write_reg(logic [CSR_IDX_W-1:0] index, int value);
      @(negedge clock);
      csr_if.index <= index;
      csr_if.data <= value[CSR_DATA_W-1:0];
      csr_if.valid <= 1'b1;
      do @(posedge clock); while (!csr_if.ready);
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   task automatic program_csrs(int w, int h, int wl, int gl, int pattern);
      write_reg(CSR_GRID_WIDTH, w);
      write_reg(CSR_GRID_HEIGHT, h);
      write_reg(CSR_WATER_LEVEL, wl);
      write_reg(CSR_GRASS_LEVEL, gl);
      write_reg(CSR_TEST_PATTERN, pattern);
      plan_w = clamp_dim(w, MAX_COLS);
      plan_h = clamp_dim(h, MAX_ROWS);
      plan_wl = wl;
      plan_gl = gl;
   endtask

   task automatic wait_idle();
      while (cell_cmds.size() != 0 || req_if.valid || pending_tiles.size() != 0)
         @(posedge clock);
      // loads and unused words give no reply but may still be in flight
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // fill every cell, run, then random traffic over the same grid
   task automatic run_phase(int w, int h, int wl, int gl, int pattern, int sand_pct,
                            int n_rand, bit hold);
      int c, r, k, roll;
      wait_idle();
      program_csrs(w, h, wl, gl, pattern);
      for (r = 0; r < plan_h; r++)
         for (c = 0; c < plan_w; c++)
            queue_cmd(MODE_LOAD, c, r, pick_sample(sand_pct));
      queue_cmd(MODE_RUN, $urandom_range(0, 63), $urandom_range(0, 63), $urandom);
      if (hold) begin
         wait_idle();
         hold_req++;
      end
      for (k = 0; k < n_rand; k++) begin
         roll = $urandom_range(0, 99);
         if (roll >= 82 && roll < 95 && plan_w == MAX_COLS && plan_h == MAX_ROWS) roll = 50;
         if (roll < 38) begin
            queue_cmd(MODE_LOAD, $urandom_range(0, plan_w - 1), $urandom_range(0, plan_h - 1),
                      pick_sample(sand_pct));
         end else if (roll < 75) begin
            queue_cmd(MODE_READ, $urandom_range(0, plan_w - 1), $urandom_range(0, plan_h - 1),
                      $urandom);
         end else if (roll < 82) begin
            queue_cmd(MODE_RUN, $urandom_range(0, 63), $urandom_range(0, 63), $urandom);
         end else if (roll < 95) begin
            // a cell beyond the grid in one direction or both
            if (plan_w < MAX_COLS && (plan_h == MAX_ROWS || $urandom_range(0, 1))) begin
               c = $urandom_range(plan_w, 63);
               r = $urandom_range(0, 63);
            end else begin
               c = $urandom_range(0, 63);
               r = $urandom_range(plan_h, 63);
            end
            queue_cmd(roll < 88 ? MODE_LOAD : MODE_READ, c, r, $urandom);
         end else begin
            queue_cmd(MODE_NONE, $urandom_range(0, 63), $urandom_range(0, 63), $urandom);
         end
      end
   endtask

   initial begin : stimulus
      int k;
      int shore_samples[12];
      req_if.valid = 1'b0;
      req_if.mode = MODE_LOAD;
      req_if.col = '0;
      req_if.row = '0;
      req_if.sample = '0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.index = CSR_GRID_WIDTH;
      csr_if.data = '0;
      reset = 1'b1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // small hand-made grid: threshold edges, extremes and stale distances
      program_csrs(4, 3, 19661, 32768, 0);
      shore_samples = '{0, 19660, 19661, 32767, 32768, 65535, 40000, 10000,
                        50000, 50000, 5000, 5000};
      for (k = 0; k < 12; k++) queue_cmd(MODE_LOAD, k % 4, k / 4, shore_samples[k]);
      queue_cmd(MODE_LOAD, 4, 0, 0);
      queue_cmd(MODE_LOAD, 63, 63, 65535);
      queue_cmd(MODE_RUN, 0, 0, 0);
      queue_cmd(MODE_READ, 0, 0, 0);
      queue_cmd(MODE_READ, 1, 1, 0);
      queue_cmd(MODE_READ, 2, 2, 0);
      queue_cmd(MODE_READ, 0, 2, 0);
      queue_cmd(MODE_READ, 3, 1, 0);
      queue_cmd(MODE_READ, 63, 63, 65535);
      queue_cmd(MODE_NONE, 63, 63, 65535);
      // former sand cell reloaded as water then grass keeps distance zero
      queue_cmd(MODE_LOAD, 2, 0, 0);
      queue_cmd(MODE_READ, 2, 0, 0);
      queue_cmd(MODE_LOAD, 2, 0, 65535);
      queue_cmd(MODE_READ, 2, 0, 0);

      run_phase(6, 6, 19661, 32768, 0, 20, 20, 1'b0);
      run_phase(0, 0, 0, 65535, 0, 30, 10, 1'b0);
      run_phase(127, 1, 30000, 30001, 0, 10, 10, 1'b0);
      run_phase(1, 20, 65535, 0, 1, 0, 15, 1'b0);
      run_phase(4, 4, 20000, 20000, 0, 0, 15, 1'b0);
      run_phase(6, 5, 10000, 50000, 0, 3, 50, 1'b1);
      run_phase(5, 7, 19661, 32768, 1, 20, 15, 1'b0);
      run_phase(10, 3, 25000, 40000, 0, 15, 20, 1'b0);
      run_phase(3, 1, 0, 0, 0, 0, 10, 1'b0);
      wait_idle();

      if (failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin : watchdog
      #4_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
